### rtl/keyed_lru_replay_cache_assert.svh
// Assertion macros used by the checker file.
`ifndef KEYED_LRU_REPLAY_CACHE_ASSERT_SVH
`define KEYED_LRU_REPLAY_CACHE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define KRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("krc check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define KRC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("krc check failed");

`endif

### rtl/krc_pkg.sv
`default_nettype none

package krc_pkg;

  // Number of table slots (1 to 64).
  localparam int unsigned Capacity = 16;
  // Slot index width, at least one bit.
  localparam int unsigned IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;

  localparam int unsigned NodeW = 32;
  localparam int unsigned MaskW = 32;
  localparam int unsigned SizeW = 16;
  localparam int unsigned TickW = 64;
  localparam int unsigned RevW  = 64;
  localparam int unsigned SlotW = 4;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic             hit_found;
    logic [IdxW-1:0]  hit_idx;
    logic             size_same;
    logic             free_found;
    logic [IdxW-1:0]  free_idx;
    logic             min_found;
    logic [TickW-1:0] min_tick;
    logic [IdxW-1:0]  min_idx;
  } token_t;

  // Write command broadcast to all cells.
  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  idx;
    logic             set_key;
    logic [TickW-1:0] tick;
  } wr_cmd_t;

  // Slot index as carried on the result port (modulo 16).
  function automatic logic [SlotW-1:0] slot_field(input logic [IdxW-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[SlotW-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/krc_cell.sv
`default_nettype none

module krc_cell (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [krc_pkg::IdxW-1:0]    cell_idx_i,
  input  wire logic [krc_pkg::NodeW-1:0]   node_i,
  input  wire logic [krc_pkg::MaskW-1:0]   mask_i,
  input  wire logic [krc_pkg::SizeW-1:0]   width_i,
  input  wire logic [krc_pkg::SizeW-1:0]   height_i,
  input  wire logic                        clear_i,
  input  wire krc_pkg::wr_cmd_t            wr_i,
  input  wire krc_pkg::token_t             tok_i,
  output krc_pkg::token_t                  tok_o
);
  import krc_pkg::*;

  logic             valid_q;
  logic [NodeW-1:0] node_q;
  logic [MaskW-1:0] mask_q;
  logic [SizeW-1:0] width_q;
  logic [SizeW-1:0] height_q;
  logic [TickW-1:0] tick_q;

  logic   match;
  logic   sel;
  token_t tok_d;
  token_t tok_q;

  assign match = valid_q && (node_q == node_i) && (mask_q == mask_i);
  assign sel   = wr_i.we && (wr_i.idx == cell_idx_i);

  // Fold this slot into the token: first key match, first free, oldest tick
  always_comb begin
    tok_d = tok_i;
    if (!tok_i.hit_found && match) begin
      tok_d.hit_found = 1'b1;
      tok_d.hit_idx   = cell_idx_i;
      tok_d.size_same = (width_q == width_i) && (height_q == height_i);
    end
    if (!tok_i.free_found && !valid_q) begin
      tok_d.free_found = 1'b1;
      tok_d.free_idx   = cell_idx_i;
    end
    if (!tok_i.min_found || (tick_q < tok_i.min_tick)) begin
      tok_d.min_found = 1'b1;
      tok_d.min_tick  = tick_q;
      tok_d.min_idx   = cell_idx_i;
    end
  end

  // Token stage to the next cell
  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign tok_o = tok_q;

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clear_i) begin
      valid_q <= 1'b0;
    end else if (sel) begin
      valid_q <= 1'b1;
    end
  end

  // Slot payload
  always_ff @(posedge clk_i) begin
    if (sel) begin
      width_q  <= width_i;
      height_q <= height_i;
      tick_q   <= wr_i.tick;
      if (wr_i.set_key) begin
        node_q <= node_i;
        mask_q <= mask_i;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/keyed_lru_replay_cache.sv
`default_nettype none
// Channel   Handshake                 Payload
// request   start, busy               cmd_i node_key_i mask_key_i ref_width_i ref_height_i
//                                     revision_i
// result    done_o (one-cycle strobe) hit_o rebuild_o slot_o evicted_o revision_out_o
//
// A clear request: done_o strobes in the cycle after acceptance and busy stays low.
// An access: the search token walks the chain of slot cells one cell per clock, then the
// ST_WRITE state decides and writes the chosen slot; done_o follows.
// busy is high while an access is in the search and write states, and low again when done_o strobes.
// Reset clears all slot valid bits and the tick counter at once; no sweep is needed.
// The receiver cannot stall: each result is shown for exactly one cycle.

module keyed_lru_replay_cache (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        cmd_i,
  input  wire logic [krc_pkg::NodeW-1:0]   node_key_i,
  input  wire logic [krc_pkg::MaskW-1:0]   mask_key_i,
  input  wire logic [krc_pkg::SizeW-1:0]   ref_width_i,
  input  wire logic [krc_pkg::SizeW-1:0]   ref_height_i,
  input  wire logic [krc_pkg::RevW-1:0]    revision_i,
  output logic                             done_o,
  output logic                             hit_o,
  output logic                             rebuild_o,
  output logic [krc_pkg::SlotW-1:0]        slot_o,
  output logic                             evicted_o,
  output logic [krc_pkg::RevW-1:0]         revision_out_o
);
  import krc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WRITE
  } state_e;

  state_e           state_q;
  logic [IdxW-1:0]  cnt_q;
  logic [TickW-1:0] tick_q;

  logic [NodeW-1:0] node_q;
  logic [MaskW-1:0] mask_q;
  logic [SizeW-1:0] width_q;
  logic [SizeW-1:0] height_q;
  logic [RevW-1:0]  rev_q;

  logic    accept;
  logic    clear;
  logic    hit_d;
  logic    rebuild_d;
  logic    evicted_d;
  token_t  tok_init;
  token_t  tail;
  wr_cmd_t wr;

  token_t  tok_chain [Capacity+1];

  assign accept = start && !busy;
  assign clear  = accept && cmd_i;
  assign busy   = (state_q != ST_IDLE);

  // Empty token entering the head of the chain
  always_comb begin
    tok_init = '0;
  end

  assign tok_chain[0] = tok_init;
  assign tail         = tok_chain[Capacity];

  // Row of slot cells
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    krc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IdxW'(i)),
      .node_i     (node_q),
      .mask_i     (mask_q),
      .width_i    (width_q),
      .height_i   (height_q),
      .clear_i    (clear),
      .wr_i       (wr),
      .tok_i      (tok_chain[i]),
      .tok_o      (tok_chain[i+1])
    );
  end

  // Decide from the token at the tail: hit, free fill or LRU eviction
  always_comb begin
    wr        = '0;
    hit_d     = 1'b0;
    rebuild_d = 1'b1;
    evicted_d = 1'b0;
    wr.tick   = tick_q;
    if (tail.hit_found) begin
      wr.idx    = tail.hit_idx;
      hit_d     = tail.size_same;
      rebuild_d = !tail.size_same;
    end else if (tail.free_found) begin
      wr.idx     = tail.free_idx;
      wr.set_key = 1'b1;
    end else begin
      wr.idx     = tail.min_idx;
      wr.set_key = 1'b1;
      evicted_d  = 1'b1;
    end
    wr.we = (state_q == ST_WRITE);
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      node_q   <= node_key_i;
      mask_q   <= mask_key_i;
      width_q  <= ref_width_i;
      height_q <= ref_height_i;
      rev_q    <= (revision_i == '0) ? RevW'(1) : revision_i;
    end
  end

  // Sequencer, tick counter and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cnt_q          <= '0;
      tick_q         <= '0;
      done_o         <= 1'b0;
      hit_o          <= 1'b0;
      rebuild_o      <= 1'b0;
      slot_o         <= '0;
      evicted_o      <= 1'b0;
      revision_out_o <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (clear) begin
            done_o         <= 1'b1;
            hit_o          <= 1'b0;
            rebuild_o      <= 1'b0;
            slot_o         <= '0;
            evicted_o      <= 1'b0;
            revision_out_o <= (revision_i == '0) ? RevW'(1) : revision_i;
          end else if (accept) begin
            tick_q  <= tick_q + TickW'(1);
            cnt_q   <= '0;
            state_q <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          cnt_q <= cnt_q + IdxW'(1);
          if (cnt_q == IdxW'(Capacity - 1)) begin
            state_q <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          done_o         <= 1'b1;
          hit_o          <= hit_d;
          rebuild_o      <= rebuild_d;
          slot_o         <= slot_field(wr.idx);
          evicted_o      <= evicted_d;
          revision_out_o <= rev_q;
          state_q        <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/krc_check.sv
`default_nettype none
`include "keyed_lru_replay_cache_assert.svh"

module krc_check (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        cmd_i,
  input wire logic [krc_pkg::NodeW-1:0]   node_key_i,
  input wire logic [krc_pkg::MaskW-1:0]   mask_key_i,
  input wire logic [krc_pkg::SizeW-1:0]   ref_width_i,
  input wire logic [krc_pkg::SizeW-1:0]   ref_height_i,
  input wire logic [krc_pkg::RevW-1:0]    revision_i,
  input wire logic                        done_o,
  input wire logic                        hit_o,
  input wire logic                        rebuild_o,
  input wire logic [krc_pkg::SlotW-1:0]   slot_o,
  input wire logic                        evicted_o,
  input wire logic [krc_pkg::RevW-1:0]    revision_out_o
);
  import krc_pkg::*;

  // A result is never both a hit and a rebuild
  `KRC_ASSERT_IMP(a_hit_xor_rebuild, done_o, !(hit_o && rebuild_o))
  // Eviction only comes with a rebuild
  `KRC_ASSERT_IMP(a_evict_rebuild, done_o && evicted_o, rebuild_o)
  // Revision zero never leaves the block
  `KRC_ASSERT_IMP(a_rev_nonzero, done_o, revision_out_o != '0)
  // An accepted access keeps the block busy
  `KRC_ASSERT_NXT(a_access_busy, start && !busy && !cmd_i, busy && !done_o)

endmodule

bind keyed_lru_replay_cache krc_check u_krc_check (.*);

`default_nettype wire
